// ----- rtl/ida_pkg.sv -----
// ----------------------------------------------------------------------------
// ida_pkg
// Shared types and constants of the ID pool allocator.
// ----------------------------------------------------------------------------
package ida_pkg;

   localparam int WORD_W  = 32;   // bitmap word
   localparam int BIT_W   = 5;    // bit index in a word
   localparam int ID_W    = 16;   // request id field
   localparam int FIELD_W = 11;   // active_ids, given_id, used_count

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_MARK  = 2'd2;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_MARK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic {
      FE_IDLE,
      FE_DIV
   } fe_state_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SCAN,
      BK_RMW
   } bk_state_type;

   typedef struct packed {
      logic [1:0]      func;
      logic [ID_W-1:0] req_id;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] given_id;
      logic               changed;
      logic [FIELD_W-1:0] used_count;
   } rsp_type;

endpackage

// ----- rtl/ida_ram.sv -----
// ----------------------------------------------------------------------------
// ida_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ida_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ida_queue.sv -----
// ----------------------------------------------------------------------------
// ida_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module ida_queue #(
   parameter int WIDTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wp_ff, wp_in;
   logic             rp_ff, rp_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      count_in = count_ff;
      if (push) begin
         wp_in = ~wp_ff;
      end
      if (pop) begin
         rp_in = ~rp_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rp_ff];
   assign full     = count_ff[1];
   assign empty    = (count_ff == 2'd0);

endmodule

// ----- rtl/ida_front.sv -----
// ----------------------------------------------------------------------------
// ida_front
// Accepts requests, decodes the operation and reduces the id to a slot
// index with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module ida_front #(
   parameter int ACT_W = 11,
   parameter int SA_W  = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ida_pkg::req_type     req_item,
   input  logic [ACT_W-1:0]     active,
   input  logic                 q_full,
   input  logic                 clearing,
   output logic                 busy,
   output logic                 q_push,
   output ida_pkg::op_type      q_op,
   output logic [SA_W-1:0]      q_slot
);

   import ida_pkg::*;

   localparam int CNT_W = $clog2(ID_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ID_W - 1);

   fe_state_type     state_ff, state_in;
   logic [ACT_W-1:0] rem_ff, rem_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   op_type           op_ff, op_in;

   logic             accept;
   logic [ACT_W:0]   shifted;
   logic [ACT_W:0]   reduced;

   assign busy   = (state_ff != FE_IDLE) || q_full || clearing;
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      id_in    = id_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      q_push   = 1'b0;
      q_op     = OP_NOP;
      q_slot   = '0;
      shifted  = {rem_ff, id_ff[ID_W-1]};
      reduced  = (shifted >= {1'b0, active}) ? (shifted - {1'b0, active}) : shifted;
      case (state_ff)
         FE_IDLE: begin
            if (accept) begin
               case (req_item.func)
                  FUNC_FREE, FUNC_MARK: begin
                     op_in    = (req_item.func == FUNC_FREE) ? OP_FREE : OP_MARK;
                     rem_in   = '0;
                     id_in    = req_item.req_id;
                     cnt_in   = '0;
                     state_in = FE_DIV;
                  end
                  FUNC_ALLOC: begin
                     q_push = 1'b1;
                     q_op   = OP_ALLOC;
                  end
                  default: begin
                     q_push = 1'b1;
                     q_op   = OP_NOP;
                  end
               endcase
            end
         end
         FE_DIV: begin
            rem_in = ACT_W'(reduced);
            id_in  = id_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               // id zero or a multiple of the size wraps to the last slot
               q_push   = 1'b1;
               q_op     = op_ff;
               q_slot   = (rem_in == '0) ? SA_W'(active - ACT_W'(1))
                                         : SA_W'(rem_in - ACT_W'(1));
               state_in = FE_IDLE;
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      id_ff  <= id_in;
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
   end

endmodule

// ----- rtl/ida_back.sv -----
// ----------------------------------------------------------------------------
// ida_back
// Executes queued operations on the in-use bitmap: next-fit word scan
// for allocate, read-modify-write for free and mark, clearing after reset.
// ----------------------------------------------------------------------------
module ida_back #(
   parameter int ACT_W  = 11,
   parameter int NWORDS = 32,
   parameter int WIDX_W = 5,
   parameter int SA_W   = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ACT_W-1:0]     active,
   input  logic                 q_empty,
   input  ida_pkg::op_type      q_op,
   input  logic [SA_W-1:0]      q_slot,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 rsp_strobe,
   output ida_pkg::rsp_type     rsp_item
);

   import ida_pkg::*;

   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

   bk_state_type      state_ff, state_in;
   logic [WIDX_W-1:0] clr_ff, clr_in;
   logic [WIDX_W-1:0] nxt_w_ff, nxt_w_in;
   logic [WIDX_W-1:0] cur_w_ff, cur_w_in;
   logic              cur_first_ff, cur_first_in;
   op_type            op_ff, op_in;
   logic [SA_W-1:0]   slot_ff, slot_in;
   logic [ACT_W-1:0]  used_ff, used_in;
   logic [ACT_W-1:0]  search_ff, search_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [WIDX_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [WIDX_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic [SA_W-1:0]   start_sa;
   logic [SA_W-1:0]   last_sa;
   logic [WIDX_W-1:0] last_w;
   logic [BIT_W-1:0]  last_bit;
   logic [WIDX_W-1:0] start_w;
   logic [WORD_W-1:0] lo_mask;
   logic [WORD_W-1:0] hi_mask;
   logic [WORD_W-1:0] free_vec;
   logic              found;
   logic [BIT_W-1:0]  fbit;
   logic [SA_W:0]     alloc_id;
   logic              cur_bit;

   ida_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (NWORDS),
      .ADDR_W (WIDX_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign start_sa = (search_ff == active) ? '0 : SA_W'(search_ff);
   assign start_w  = start_sa[SA_W-1:BIT_W];
   assign last_sa  = SA_W'(active - ACT_W'(1));
   assign last_w   = last_sa[SA_W-1:BIT_W];
   assign last_bit = last_sa[BIT_W-1:0];

   // first free slot of the word on the read port
   always_comb begin
      lo_mask  = cur_first_ff ? ({WORD_W{1'b1}} << slot_ff[BIT_W-1:0]) : {WORD_W{1'b1}};
      hi_mask  = (cur_w_ff == last_w) ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit))
                                      : {WORD_W{1'b1}};
      free_vec = ~rd_data & lo_mask & hi_mask;
      found    = 1'b0;
      fbit     = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            found = 1'b1;
            fbit  = BIT_W'(i);
         end
      end
      alloc_id = {1'b0, cur_w_ff, fbit} + (SA_W + 1)'(1);
      cur_bit  = rd_data[slot_ff[BIT_W-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      nxt_w_in      = nxt_w_ff;
      cur_w_in      = cur_w_ff;
      cur_first_in  = cur_first_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      used_in       = used_ff;
      search_in     = search_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + WIDX_W'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_op)
                  OP_ALLOC: begin
                     if (used_ff >= active) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = start_w;
                        cur_w_in     = start_w;
                        cur_first_in = 1'b1;
                        nxt_w_in     = (start_w == last_w) ? '0 : start_w + WIDX_W'(1);
                        slot_in      = start_sa;
                        state_in     = BK_SCAN;
                     end
                  end
                  OP_FREE, OP_MARK: begin
                     rd_en    = 1'b1;
                     rd_addr  = q_slot[SA_W-1:BIT_W];
                     slot_in  = q_slot;
                     op_in    = q_op;
                     state_in = BK_RMW;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (found) begin
               wr_en              = 1'b1;
               wr_addr            = cur_w_ff;
               wr_data            = rd_data | (WORD_W'(1) << fbit);
               used_in            = used_ff + ACT_W'(1);
               search_in          = ACT_W'(alloc_id);
               rsp_strobe_in      = 1'b1;
               rsp_in.given_id    = FIELD_W'(alloc_id);
               rsp_in.changed     = 1'b1;
               state_in           = BK_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = nxt_w_ff;
               cur_w_in     = nxt_w_ff;
               cur_first_in = 1'b0;
               nxt_w_in     = (nxt_w_ff == last_w) ? '0 : nxt_w_ff + WIDX_W'(1);
            end
         end
         BK_RMW: begin
            wr_addr       = slot_ff[SA_W-1:BIT_W];
            rsp_strobe_in = 1'b1;
            state_in      = BK_IDLE;
            if (op_ff == OP_FREE) begin
               if (cur_bit) begin
                  wr_en          = 1'b1;
                  wr_data        = rd_data & ~(WORD_W'(1) << slot_ff[BIT_W-1:0]);
                  used_in        = used_ff - ACT_W'(1);
                  rsp_in.changed = 1'b1;
               end
            end else begin
               if (!cur_bit) begin
                  wr_en          = 1'b1;
                  wr_data        = rd_data | (WORD_W'(1) << slot_ff[BIT_W-1:0]);
                  used_in        = used_ff + ACT_W'(1);
                  rsp_in.changed = 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_in.used_count = FIELD_W'(used_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         clr_ff        <= '0;
         used_ff       <= '0;
         search_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         used_ff       <= used_in;
         search_ff     <= search_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_w_ff     <= nxt_w_in;
      cur_w_ff     <= cur_w_in;
      cur_first_ff <= cur_first_in;
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      rsp_ff       <= rsp_in;
   end

   assign clearing   = (state_ff == BK_CLEAR);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- rtl/id_pool_allocator_core.sv -----
// ----------------------------------------------------------------------------
// id_pool_allocator_core
// Next-fit bitmap ID allocator: allocate, free and mark requests on a pool
// of IDs 1..active_ids, every response carrying the in-use count.
//
//   port group   direction  handshake
//   req_*        in         start / busy, taken when start & !busy
//   rsp_*        out        rsp_strobe, one cycle, no back-pressure
//   csr_*        in         csr_wr_en, single register active_ids
//
// Allocate: one bitmap word per cycle from the RAM read port, at most
// NWORDS+1 words. Free / mark: bit-serial id reduction in the front,
// then a read-modify-write in the back. The front takes the next beat
// while the back works. After reset the bitmap is cleared one word per
// cycle; busy stays high meanwhile.
// ----------------------------------------------------------------------------
module id_pool_allocator_core #(
   parameter int POOL_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ida_pkg::req_type              req_item,
   output logic                          rsp_strobe,
   output ida_pkg::rsp_type              rsp_item,
   input  logic                          csr_wr_en,
   input  logic [ida_pkg::FIELD_W-1:0]   csr_wr_data
);

   import ida_pkg::*;

   localparam int ACT_W  = $clog2(POOL_SIZE + 1);
   localparam int NWORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
   localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int SA_W   = WIDX_W + BIT_W;
   localparam int CMP_W  = (ACT_W > FIELD_W) ? ACT_W : FIELD_W;
   localparam int Q_W    = 2 + SA_W;

   logic [ACT_W-1:0] active_ff, active_in;
   logic [CMP_W-1:0] wr_ext;
   logic [CMP_W-1:0] wr_sat;

   logic             q_push;
   op_type           q_push_op;
   logic [SA_W-1:0]  q_push_slot;
   logic             q_pop;
   logic [Q_W-1:0]   q_pop_data;
   logic             q_full;
   logic             q_empty;
   logic             clearing;

   // active size only grows, saturated to the pool
   always_comb begin
      wr_ext    = CMP_W'(csr_wr_data);
      wr_sat    = (wr_ext > CMP_W'(POOL_SIZE)) ? CMP_W'(POOL_SIZE) : wr_ext;
      active_in = active_ff;
      if (csr_wr_en && (wr_sat > CMP_W'(active_ff))) begin
         active_in = ACT_W'(wr_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACT_W'(POOL_SIZE);
      end else begin
         active_ff <= active_in;
      end
   end

   ida_front #(
      .ACT_W (ACT_W),
      .SA_W  (SA_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .active   (active_ff),
      .q_full   (q_full),
      .clearing (clearing),
      .busy     (busy),
      .q_push   (q_push),
      .q_op     (q_push_op),
      .q_slot   (q_push_slot)
   );

   ida_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({q_push_op, q_push_slot}),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   ida_back #(
      .ACT_W  (ACT_W),
      .NWORDS (NWORDS),
      .WIDX_W (WIDX_W),
      .SA_W   (SA_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .active     (active_ff),
      .q_empty    (q_empty),
      .q_op       (op_type'(q_pop_data[Q_W-1:SA_W])),
      .q_slot     (q_pop_data[SA_W-1:0]),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy)
      else $error("beat accepted while bitmap clear runs");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (!q_full || q_pop))
      else $error("queue overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue underflow");

   a_alloc_changed: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.given_id != '0)) |-> rsp_item.changed)
      else $error("allocated id without a claimed slot");

endmodule
